// File: sv/assert_macros.svh
// assertion macros shared by the gesture detector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, idle while rst_n is low
`define GGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on clk, active during reset as well
`define GGD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/ggd_pkg.sv
// shared types and constants for the gyro gesture detector
package ggd_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_VERTICAL_TRIGGER   = 3'd0;
  localparam logic [2:0] REG_VERTICAL_RETURN    = 3'd1;
  localparam logic [2:0] REG_HORIZONTAL_TRIGGER = 3'd2;
  localparam logic [2:0] REG_HORIZONTAL_RETURN  = 3'd3;
  localparam logic [2:0] REG_RELEASE_LEVEL      = 3'd4;
  localparam logic [2:0] REG_QUIET_TIME_MS      = 3'd5;

  localparam logic [14:0] RST_VERTICAL_TRIGGER   = 15'd55;
  localparam logic [14:0] RST_VERTICAL_RETURN    = 15'd25;
  localparam logic [15:0] RST_HORIZONTAL_TRIGGER = 16'd40;
  localparam logic [15:0] RST_HORIZONTAL_RETURN  = 16'd20;
  localparam logic [14:0] RST_RELEASE_LEVEL      = 15'd20;
  localparam logic [7:0]  RST_QUIET_TIME_MS      = 8'd100;

  localparam logic [1:0] HDG_UP    = 2'd0;
  localparam logic [1:0] HDG_RIGHT = 2'd1;
  localparam logic [1:0] HDG_DOWN  = 2'd2;
  localparam logic [1:0] HDG_LEFT  = 2'd3;

  typedef struct packed {
    logic [14:0] vertical_trigger;
    logic [14:0] vertical_return;
    logic [15:0] horizontal_trigger;
    logic [15:0] horizontal_return;
    logic [14:0] release_level;
    logic [7:0]  quiet_time_ms;
  } ggd_cfg_t;

  typedef struct packed {
    logic [1:0]         current_heading;
    logic               blocked;
    logic               turn_pending;
    logic [7:0]         elapsed;
    logic signed [15:0] rate_z;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
  } ggd_sample_t;

  typedef struct packed {
    logic       gesture;
    logic [1:0] det;
    logic       ret_up;
    logic       ret_down;
    logic       ret_left;
    logic       ret_right;
    logic       quiet;
  } ggd_class_t;

  typedef struct packed {
    logic       is_armed;
    logic [1:0] command_direction;
    logic       command_valid;
  } ggd_result_t;

endpackage

// File: sv/ggd_cfg_regs.sv
// configuration register file behind the apb-style port
module ggd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ggd_pkg::CFG_AW-1:0] paddr,
  input  logic [ggd_pkg::CFG_DW-1:0] pwdata,
  output logic [ggd_pkg::CFG_DW-1:0] prdata,
  output ggd_pkg::ggd_cfg_t          cfg
);

  ggd_pkg::ggd_cfg_t cfg_r;
  ggd_pkg::ggd_cfg_t cfg_nxt;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        ggd_pkg::REG_VERTICAL_TRIGGER:   cfg_nxt.vertical_trigger   = pwdata[14:0];
        ggd_pkg::REG_VERTICAL_RETURN:    cfg_nxt.vertical_return    = pwdata[14:0];
        ggd_pkg::REG_HORIZONTAL_TRIGGER: cfg_nxt.horizontal_trigger = pwdata[15:0];
        ggd_pkg::REG_HORIZONTAL_RETURN:  cfg_nxt.horizontal_return  = pwdata[15:0];
        ggd_pkg::REG_RELEASE_LEVEL:      cfg_nxt.release_level      = pwdata[14:0];
        ggd_pkg::REG_QUIET_TIME_MS:      cfg_nxt.quiet_time_ms      = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertical_trigger   <= ggd_pkg::RST_VERTICAL_TRIGGER;
      cfg_r.vertical_return    <= ggd_pkg::RST_VERTICAL_RETURN;
      cfg_r.horizontal_trigger <= ggd_pkg::RST_HORIZONTAL_TRIGGER;
      cfg_r.horizontal_return  <= ggd_pkg::RST_HORIZONTAL_RETURN;
      cfg_r.release_level      <= ggd_pkg::RST_RELEASE_LEVEL;
      cfg_r.quiet_time_ms      <= ggd_pkg::RST_QUIET_TIME_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      ggd_pkg::REG_VERTICAL_TRIGGER:   prdata = {17'd0, cfg_r.vertical_trigger};
      ggd_pkg::REG_VERTICAL_RETURN:    prdata = {17'd0, cfg_r.vertical_return};
      ggd_pkg::REG_HORIZONTAL_TRIGGER: prdata = {16'd0, cfg_r.horizontal_trigger};
      ggd_pkg::REG_HORIZONTAL_RETURN:  prdata = {16'd0, cfg_r.horizontal_return};
      ggd_pkg::REG_RELEASE_LEVEL:      prdata = {17'd0, cfg_r.release_level};
      ggd_pkg::REG_QUIET_TIME_MS:      prdata = {24'd0, cfg_r.quiet_time_ms};
      default:                         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: sv/ggd_classify.sv
// sample classification: gesture direction, return peaks and quiet test
module ggd_classify (
  input  ggd_pkg::ggd_sample_t smp,
  input  ggd_pkg::ggd_cfg_t    cfg,
  output ggd_pkg::ggd_class_t  cls
);

  logic signed [16:0] h;
  logic [16:0]        ah;
  logic [15:0]        az;
  logic [15:0]        ax;
  logic [15:0]        ay;
  logic               vert;
  logic               horz;
  logic               z_ret;
  logic               h_ret;

  // horizontal motion is x minus y, one bit wider to avoid overflow
  assign h  = {smp.rate_x[15], smp.rate_x} - {smp.rate_y[15], smp.rate_y};
  assign ah = h[16] ? 17'(~h + 17'sd1) : 17'(h);
  assign az = smp.rate_z[15] ? 16'(~smp.rate_z + 16'sd1) : 16'(smp.rate_z);
  assign ax = smp.rate_x[15] ? 16'(~smp.rate_x + 16'sd1) : 16'(smp.rate_x);
  assign ay = smp.rate_y[15] ? 16'(~smp.rate_y + 16'sd1) : 16'(smp.rate_y);

  assign vert = (az >= {1'b0, cfg.vertical_trigger}) && ({1'b0, az} > ah);
  assign horz = (ah >= {1'b0, cfg.horizontal_trigger}) && (ah > {1'b0, az});

  // a return peak is a sign check plus a magnitude above the return level
  assign z_ret = az > {1'b0, cfg.vertical_return};
  assign h_ret = ah > {1'b0, cfg.horizontal_return};

  always_comb begin
    cls.gesture = vert || horz;
    if (vert) begin
      cls.det = smp.rate_z[15] ? ggd_pkg::HDG_DOWN : ggd_pkg::HDG_UP;
    end else if (horz) begin
      cls.det = h[16] ? ggd_pkg::HDG_LEFT : ggd_pkg::HDG_RIGHT;
    end else begin
      cls.det = ggd_pkg::HDG_UP;
    end
    cls.ret_up    = smp.rate_z[15] && z_ret;
    cls.ret_down  = !smp.rate_z[15] && z_ret;
    cls.ret_left  = !h[16] && h_ret;
    cls.ret_right = h[16] && h_ret;
    cls.quiet     = (ax < {1'b0, cfg.release_level}) &&
                    (ay < {1'b0, cfg.release_level}) &&
                    (az < {1'b0, cfg.release_level});
  end

endmodule

// File: sv/ggd_tracker.sv
// arming state, return and quiet tracking, command issue
`include "assert_macros.svh"

module ggd_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  ggd_pkg::ggd_sample_t smp,
  input  ggd_pkg::ggd_class_t  cls,
  input  ggd_pkg::ggd_cfg_t    cfg,
  output ggd_pkg::ggd_result_t res
);

  logic       armed_r, armed_nxt;
  logic       return_seen_r, return_seen_nxt;
  logic [7:0] quiet_cnt_r, quiet_cnt_nxt;
  logic [1:0] last_r, last_nxt;
  logic       perp;
  logic       ret_hit;
  logic [8:0] q_sum;
  logic       try_issue;
  logic       cmd;

  // a direction differs from d and its opposite exactly when bit 0 differs
  assign perp = !smp.turn_pending && cls.gesture && (cls.det[0] != last_r[0]);

  always_comb begin
    case (last_r)
      ggd_pkg::HDG_UP:    ret_hit = cls.ret_up;
      ggd_pkg::HDG_DOWN:  ret_hit = cls.ret_down;
      ggd_pkg::HDG_LEFT:  ret_hit = cls.ret_left;
      ggd_pkg::HDG_RIGHT: ret_hit = cls.ret_right;
      default:            ret_hit = 1'b0;
    endcase
  end

  assign q_sum = {1'b0, quiet_cnt_r} + {1'b0, smp.elapsed};

  always_comb begin
    armed_nxt       = armed_r;
    return_seen_nxt = return_seen_r;
    quiet_cnt_nxt   = quiet_cnt_r;
    last_nxt        = last_r;
    try_issue       = 1'b0;
    if (!armed_r) begin
      if (perp) begin
        last_nxt        = cls.det;
        return_seen_nxt = 1'b0;
        quiet_cnt_nxt   = '0;
        try_issue       = 1'b1;
      end else if (!return_seen_r) begin
        if (ret_hit) begin
          return_seen_nxt = 1'b1;
          quiet_cnt_nxt   = '0;
        end
      end else if (cls.quiet) begin
        if (q_sum >= {1'b0, cfg.quiet_time_ms}) begin
          armed_nxt       = 1'b1;
          return_seen_nxt = 1'b0;
          quiet_cnt_nxt   = '0;
        end else begin
          quiet_cnt_nxt = q_sum[7:0];
        end
      end else begin
        quiet_cnt_nxt = '0;
      end
    end else if (!smp.turn_pending && !smp.blocked && cls.gesture) begin
      last_nxt        = cls.det;
      armed_nxt       = 1'b0;
      return_seen_nxt = 1'b0;
      quiet_cnt_nxt   = '0;
      try_issue       = 1'b1;
    end
  end

  assign cmd = try_issue && !smp.blocked && !smp.turn_pending &&
               (cls.det[0] != smp.current_heading[0]);

  always_comb begin
    res.command_valid     = cmd;
    res.command_direction = cmd ? cls.det : ggd_pkg::HDG_UP;
    res.is_armed          = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      return_seen_r <= 1'b1;
      quiet_cnt_r   <= '0;
      last_r        <= ggd_pkg::HDG_UP;
    end else if (step_en) begin
      armed_r       <= armed_nxt;
      return_seen_r <= return_seen_nxt;
      quiet_cnt_r   <= quiet_cnt_nxt;
      last_r        <= last_nxt;
    end
  end

  // rearming only follows a seen return peak
  `GGD_ASSERT(a_arm_after_return, $rose(armed_r) |-> $past(return_seen_r), "armed without return")
  // disarming leaves a clean wait state
  `GGD_ASSERT(a_disarm_clean, $fell(armed_r) |-> (quiet_cnt_r == 8'd0 && !return_seen_r), "dirty disarm")
  // quiet time only accumulates while waiting for quiet
  `GGD_ASSERT(a_quiet_ctx, (quiet_cnt_r != 8'd0) |-> (return_seen_r && !armed_r), "stray quiet count")

endmodule

// File: sv/gyro_gesture_detector_core.sv
// top level of the gyro gesture detector: stream ports, register stages, apb port
// Takes one raw gyro sample per word and gives exactly one result word per sample:
// command_valid, command_direction (0 up, 1 right, 2 down, 3 left) and is_armed.
// A sample can be accepted every cycle while the result side takes its words; the input
// register takes it at the accepting edge and the result register takes its result from
// the input register when it moves on, with classification and the arming state update
// done in the single path between them.
// Back-pressure on the result side stalls the input register only once the result register
// is held. Registers sit at byte addresses 0x00 vertical_trigger, 0x04 vertical_return,
// 0x08 horizontal_trigger, 0x0c horizontal_return, 0x10 release_level, 0x14 quiet_time_ms;
// the user must write them only while the block is idle, which the block does not enforce.
`include "assert_macros.svh"

module gyro_gesture_detector_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // rate_x[15:0], rate_y[31:16], rate_z[47:32], elapsed[55:48],
  // turn_pending[56], blocked[57], current_heading[59:58], zero[63:60]
  input  logic [63:0]                in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // command_valid[0], command_direction[2:1], is_armed[3], zero[7:4]
  output logic [7:0]                 out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ggd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ggd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ggd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  ggd_pkg::ggd_cfg_t    cfg;
  ggd_pkg::ggd_sample_t smp_r;
  ggd_pkg::ggd_class_t  cls;
  ggd_pkg::ggd_result_t res;
  ggd_pkg::ggd_result_t res_r;
  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic                 advance;

  assign cfg_pready = 1'b1;

  ggd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // the sample in the input register moves on when the result register is free
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      smp_r <= ggd_pkg::ggd_sample_t'(in_tdata[59:0]);
    end
  end

  ggd_classify u_classify (
    .smp (smp_r),
    .cfg (cfg),
    .cls (cls)
  );

  ggd_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .smp     (smp_r),
    .cls     (cls),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r};

  // an empty result register never blocks the input side
  `GGD_ASSERT(a_ready_when_empty, !out_valid_r |-> in_tready, "input stalled with empty output")
  // a command always leaves the detector disarmed
  `GGD_ASSERT(a_cmd_disarmed, (out_valid_r && res_r.command_valid) |-> !res_r.is_armed, "command while armed")
  // a held result word stays put until it is taken
  `GGD_ASSERT(a_out_hold, (out_valid_r && !out_tready) |=> (out_valid_r && $stable(res_r)), "held word lost")

endmodule

// File: test/tb_gyro_gesture_detector_core.sv
// testbench for gyro_gesture_detector_core: stream stimulus, predicted commands, apb setup
module tb_gyro_gesture_detector_core;

  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_GAP    = 12;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  // rate_x[15:0], rate_y[31:16], rate_z[47:32], elapsed[55:48],
  // turn_pending[56], blocked[57], current_heading[59:58], zero[63:60]
  logic [63:0]                  in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  // command_valid[0], command_direction[2:1], is_armed[3], zero[7:4]
  logic [7:0]                   out_tdata;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [ggd_pkg::CFG_AW-1:0]   cfg_paddr;
  logic [ggd_pkg::CFG_DW-1:0]   cfg_pwdata;
  logic [ggd_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  gyro_gesture_detector_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  class command_tracker;
    ggd_pkg::ggd_cfg_t    cfg;
    logic                 armed;
    logic                 ret_seen;
    logic [7:0]           quiet_ms;
    logic [1:0]           last_dir;
    ggd_pkg::ggd_result_t due_results[$];
    int                   errors;
    int                   samples;
    int                   commands;
    int                   rearms;
    int                   checked;

    function new();
      cfg.vertical_trigger   = ggd_pkg::RST_VERTICAL_TRIGGER;
      cfg.vertical_return    = ggd_pkg::RST_VERTICAL_RETURN;
      cfg.horizontal_trigger = ggd_pkg::RST_HORIZONTAL_TRIGGER;
      cfg.horizontal_return  = ggd_pkg::RST_HORIZONTAL_RETURN;
      cfg.release_level      = ggd_pkg::RST_RELEASE_LEVEL;
      cfg.quiet_time_ms      = ggd_pkg::RST_QUIET_TIME_MS;
      armed    = 1'b0;
      ret_seen = 1'b1;
      quiet_ms = '0;
      last_dir = ggd_pkg::HDG_UP;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned value);
      case (idx)
        ggd_pkg::REG_VERTICAL_TRIGGER:   cfg.vertical_trigger   = 15'(value);
        ggd_pkg::REG_VERTICAL_RETURN:    cfg.vertical_return    = 15'(value);
        ggd_pkg::REG_HORIZONTAL_TRIGGER: cfg.horizontal_trigger = 16'(value);
        ggd_pkg::REG_HORIZONTAL_RETURN:  cfg.horizontal_return  = 16'(value);
        ggd_pkg::REG_RELEASE_LEVEL:      cfg.release_level      = 15'(value);
        ggd_pkg::REG_QUIET_TIME_MS:      cfg.quiet_time_ms      = 8'(value);
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // true when the two directions lie on different axes
    function bit crosses(logic [1:0] a, logic [1:0] b);
      return a[0] != b[0];
    endfunction

    function void predict_command(ggd_pkg::ggd_sample_t s);
      int                   x, y, z, h, ax, ay, ah, az;
      int                   vt, vr, ht, hr, rl, qt, sum;
      logic                 hit, go, cmd;
      logic [1:0]           dir;
      ggd_pkg::ggd_result_t r;
      x  = $signed(s.rate_x);
      y  = $signed(s.rate_y);
      z  = $signed(s.rate_z);
      vt = cfg.vertical_trigger;
      vr = cfg.vertical_return;
      ht = cfg.horizontal_trigger;
      hr = cfg.horizontal_return;
      rl = cfg.release_level;
      qt = cfg.quiet_time_ms;
      h  = x - y;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      ah = h < 0 ? -h : h;
      az = z < 0 ? -z : z;
      hit = 1'b0;
      go  = 1'b0;
      dir = ggd_pkg::HDG_UP;
      samples++;
      if (az >= vt && az > ah) begin
        hit = 1'b1;
        dir = z > 0 ? ggd_pkg::HDG_UP : ggd_pkg::HDG_DOWN;
      end else if (ah >= ht && ah > az) begin
        hit = 1'b1;
        dir = h < 0 ? ggd_pkg::HDG_LEFT : ggd_pkg::HDG_RIGHT;
      end
      if (!armed) begin
        if (!s.turn_pending && hit && crosses(dir, last_dir)) begin
          last_dir = dir;
          ret_seen = 1'b0;
          quiet_ms = '0;
          go       = 1'b1;
        end else if (!ret_seen) begin
          if ((last_dir == ggd_pkg::HDG_UP && z < -vr) ||
              (last_dir == ggd_pkg::HDG_DOWN && z > vr) ||
              (last_dir == ggd_pkg::HDG_LEFT && h > hr) ||
              (last_dir == ggd_pkg::HDG_RIGHT && h < -hr)) begin
            ret_seen = 1'b1;
            quiet_ms = '0;
          end
        end else if (ax < rl && ay < rl && az < rl) begin
          sum = quiet_ms + s.elapsed;
          if (sum > qt) sum = qt;
          quiet_ms = 8'(sum);
          if (sum >= qt) begin
            armed    = 1'b1;
            ret_seen = 1'b0;
            quiet_ms = '0;
            rearms++;
          end
        end else begin
          quiet_ms = '0;
        end
      end else if (!s.turn_pending && !s.blocked && hit) begin
        last_dir = dir;
        armed    = 1'b0;
        ret_seen = 1'b0;
        quiet_ms = '0;
        go       = 1'b1;
      end
      cmd = go && !s.blocked && !s.turn_pending && crosses(dir, s.current_heading);
      r.command_valid     = cmd;
      r.command_direction = cmd ? dir : ggd_pkg::HDG_UP;
      r.is_armed          = armed;
      if (cmd) commands++;
      due_results.push_back(r);
    endfunction

    task check_command(logic [7:0] word);
      ggd_pkg::ggd_result_t got, want;
      got = word[3:0];
      if (due_results.size() == 0) begin
        report($sformatf("result word %h with no sample waiting", word));
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.command_valid !== want.command_valid)
        report($sformatf("result %0d command_valid got %b want %b", checked,
                         got.command_valid, want.command_valid));
      if (got.command_direction !== want.command_direction)
        report($sformatf("result %0d command_direction got %0d want %0d", checked,
                         got.command_direction, want.command_direction));
      if (got.is_armed !== want.is_armed)
        report($sformatf("result %0d is_armed got %b want %b", checked,
                         got.is_armed, want.is_armed));
      if (word[7:4] !== 4'b0000)
        report($sformatf("result %0d padding bits got %b", checked, word[7:4]));
    endtask
  endclass

  command_tracker tracker;
  bit             in_burst;
  bit             out_burst;
  int             idle_cycles = 0;
  int             settings_done = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_command(out_tdata);
  end

  // stop a hung run: no word moving on either channel and no register access
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic ggd_pkg::ggd_sample_t make_sample(int x, int y, int z, int el, bit pend,
                                                       bit blk, logic [1:0] head);
    ggd_pkg::ggd_sample_t s;
    s.rate_x          = 16'(sat16(x));
    s.rate_y          = 16'(sat16(y));
    s.rate_z          = 16'(sat16(z));
    s.elapsed         = 8'(el);
    s.turn_pending    = pend;
    s.blocked         = blk;
    s.current_heading = head;
    return s;
  endfunction

  // sample whose dominant motion points in dir with strength mag
  function automatic ggd_pkg::ggd_sample_t motion(logic [1:0] dir, int mag, int el, bit pend,
                                                  bit blk, logic [1:0] head);
    int side;
    if (mag < 0) mag = 0;
    if (mag > 65535) mag = 65535;
    side = $urandom_range(0, mag / 4);
    case (dir)
      ggd_pkg::HDG_UP:    return make_sample(side, 0, mag, el, pend, blk, head);
      ggd_pkg::HDG_DOWN:  return make_sample(0, side, -mag, el, pend, blk, head);
      ggd_pkg::HDG_RIGHT: return make_sample(mag / 2, -(mag - mag / 2), side, el, pend, blk,
                                             head);
      default:            return make_sample(-(mag - mag / 2), mag / 2, -side, el, pend, blk,
                                             head);
    endcase
  endfunction

  function automatic int level(logic [1:0] dir, bit is_return);
    if (dir[0]) return is_return ? tracker.cfg.horizontal_return : tracker.cfg.horizontal_trigger;
    return is_return ? tracker.cfg.vertical_return : tracker.cfg.vertical_trigger;
  endfunction

  function automatic int pick_elapsed();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 150;
      2:       return $urandom_range(151, 255);
      3:       return 255;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_sample(ggd_pkg::ggd_sample_t s);
    int gap;
    if ($urandom_range(0, 59) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, s};
    do @(posedge clk); while (!in_tready);
    tracker.predict_command(s);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned value);
    logic [ggd_pkg::CFG_DW-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_reg(idx, value);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    if (rd !== value)
      tracker.report($sformatf("register %0d read %0d after writing %0d", idx, rd, value));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(int unsigned vt, int unsigned vr, int unsigned ht,
                                int unsigned hr, int unsigned rl, int unsigned qt);
    in_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    write_reg(ggd_pkg::REG_VERTICAL_TRIGGER, vt);
    write_reg(ggd_pkg::REG_VERTICAL_RETURN, vr);
    write_reg(ggd_pkg::REG_HORIZONTAL_TRIGGER, ht);
    write_reg(ggd_pkg::REG_HORIZONTAL_RETURN, hr);
    write_reg(ggd_pkg::REG_RELEASE_LEVEL, rl);
    write_reg(ggd_pkg::REG_QUIET_TIME_MS, qt);
    settings_done++;
  endtask

  // mostly follows the gesture cycle: gesture, return peak, quiet until rearmed
  task automatic run_phase(int count);
    ggd_pkg::ggd_sample_t s;
    logic [63:0]          raw;
    logic [1:0]           dir, head, back, side_dir;
    bit                   pend, blk;
    int                   el, rl, lim, pick;
    for (int n = 0; n < count; n++) begin
      pend = ($urandom_range(0, 9) == 0);
      blk  = ($urandom_range(0, 9) == 0);
      head = 2'($urandom_range(0, 3));
      dir  = 2'($urandom_range(0, 3));
      el   = pick_elapsed();
      pick = $urandom_range(0, 99);
      rl   = tracker.cfg.release_level;
      back     = {~tracker.last_dir[1], tracker.last_dir[0]};
      side_dir = {1'($urandom_range(0, 1)), ~tracker.last_dir[0]};
      if (pick < 10) begin
        raw = {$urandom, $urandom};
        s = raw[59:0];
      end else if (pick < 18) begin
        s = motion(dir, level(dir, 1'b0) + int'($urandom_range(0, 2)) - 1, el, pend, blk, head);
      end else if (tracker.armed) begin
        s = motion(dir, level(dir, 1'b0) + int'($urandom_range(0, 300)), el, pend, blk, head);
      end else if (!tracker.ret_seen) begin
        if ($urandom_range(0, 3) == 0)
          s = motion(side_dir, level(side_dir, 1'b0) + int'($urandom_range(0, 300)),
                     el, pend, blk, head);
        else
          s = motion(back, level(tracker.last_dir, 1'b1) + 1 + int'($urandom_range(0, 40)),
                     el, pend, blk, head);
      end else if ($urandom_range(0, 9) == 0) begin
        s = motion(dir, rl + int'($urandom_range(0, 50)), el, pend, blk, head);
      end else begin
        lim = rl > 0 ? rl - 1 : 0;
        s = make_sample(int'($urandom_range(0, 2 * lim)) - lim,
                        int'($urandom_range(0, 2 * lim)) - lim,
                        int'($urandom_range(0, 2 * lim)) - lim, el, pend, blk, head);
      end
      send_sample(s);
    end
  endtask

  initial begin
    tracker = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed walk through the gesture cycle with reset thresholds
    send_sample(make_sample(0, 0, 0, 0, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(19, -19, 19, 150, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, 32767, 10, 1'b0, 1'b0, ggd_pkg::HDG_RIGHT));
    send_sample(make_sample(32767, -32768, 0, 10, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(-32768, 32767, 0, 10, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, 0, 255, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, -32768, 10, 1'b0, 1'b1, ggd_pkg::HDG_RIGHT));
    send_sample(make_sample(0, 0, -32768, 10, 1'b1, 1'b0, ggd_pkg::HDG_RIGHT));
    send_sample(make_sample(0, 0, -32768, 10, 1'b0, 1'b0, ggd_pkg::HDG_DOWN));
    send_sample(make_sample(-32768, 32767, 3, 10, 1'b1, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, 26, 10, 1'b0, 1'b0, ggd_pkg::HDG_LEFT));
    send_sample(make_sample(30, 30, 0, 40, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(-19, 0, 0, 60, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 19, -19, 60, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(-20, 20, 0, 10, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, 55, 10, 1'b0, 1'b1, ggd_pkg::HDG_RIGHT));
    send_sample(make_sample(0, 0, -25, 10, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, -26, 10, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(20, 0, 0, 100, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, 0, 99, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(0, 0, 0, 1, 1'b0, 1'b0, ggd_pkg::HDG_UP));
    send_sample(make_sample(60, 0, 60, 10, 1'b0, 1'b0, ggd_pkg::HDG_RIGHT));
    send_sample(make_sample(0, 0, 54, 10, 1'b0, 1'b0, ggd_pkg::HDG_LEFT));
    send_sample(make_sample(0, 0, 55, 10, 1'b0, 1'b0, ggd_pkg::HDG_LEFT));
    send_sample(make_sample(-32768, -32768, -32768, 255, 1'b1, 1'b1, ggd_pkg::HDG_LEFT));

    apply_settings($urandom_range(30, 200), $urandom_range(10, 100), $urandom_range(30, 200),
                   $urandom_range(10, 100), $urandom_range(10, 60), $urandom_range(20, 120));
    run_phase(230);
    apply_settings(0, 0, 0, 0, 0, 1);
    run_phase(130);
    // zero quiet time arms on the first quiet sample
    apply_settings($urandom_range(40, 80), $urandom_range(10, 40), $urandom_range(40, 80),
                   $urandom_range(10, 40), $urandom_range(20, 40), 0);
    run_phase(170);
    apply_settings(32767, 32767, 65535, 65535, 32767, 255);
    run_phase(170);
    apply_settings($urandom_range(30, 200), $urandom_range(10, 100), $urandom_range(30, 200),
                   $urandom_range(10, 100), $urandom_range(10, 60), 1);
    run_phase(230);
    apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 32767), $urandom_range(0, 255));
    run_phase(170);
    apply_settings(ggd_pkg::RST_VERTICAL_TRIGGER, ggd_pkg::RST_VERTICAL_RETURN,
                   ggd_pkg::RST_HORIZONTAL_TRIGGER, ggd_pkg::RST_HORIZONTAL_RETURN,
                   ggd_pkg::RST_RELEASE_LEVEL, ggd_pkg::RST_QUIET_TIME_MS);
    run_phase(230);

    in_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("run covered %0d samples, reset thresholds plus %0d written register sets",
             tracker.samples, settings_done);
    $display("%0d results checked, %0d commands issued, %0d rearms, %0d mismatches",
             tracker.checked, tracker.commands, tracker.rearms, tracker.errors);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
